FILE: hdl/rvdec_pkg.sv
// Package for the RV32I instruction decoder: opcodes, instruction codes and the decode function.
package rvdec_pkg;

  typedef logic [31:0] instr_word_t;
  typedef logic [5:0]  inst_code_t;
  typedef logic [6:0]  opcode_t;
  typedef logic [2:0]  funct3_t;
  typedef logic [6:0]  funct7_t;

  // Major opcodes (bits 6..0)
  localparam opcode_t OPC_LUI    = 7'b0110111;
  localparam opcode_t OPC_AUIPC  = 7'b0010111;
  localparam opcode_t OPC_JAL    = 7'b1101111;
  localparam opcode_t OPC_JALR   = 7'b1100111;
  localparam opcode_t OPC_BRANCH = 7'b1100011;
  localparam opcode_t OPC_LOAD   = 7'b0000011;
  localparam opcode_t OPC_STORE  = 7'b0100011;
  localparam opcode_t OPC_OPIMM  = 7'b0010011;
  localparam opcode_t OPC_OP     = 7'b0110011;
  localparam opcode_t OPC_FENCE  = 7'b0001111;
  localparam opcode_t OPC_SYSTEM = 7'b1110011;

  localparam funct7_t F7_BASE = 7'b0000000;
  localparam funct7_t F7_ALT  = 7'b0100000;

  localparam funct3_t F3_0 = 3'd0;
  localparam funct3_t F3_1 = 3'd1;
  localparam funct3_t F3_2 = 3'd2;
  localparam funct3_t F3_3 = 3'd3;
  localparam funct3_t F3_4 = 3'd4;
  localparam funct3_t F3_5 = 3'd5;
  localparam funct3_t F3_6 = 3'd6;
  localparam funct3_t F3_7 = 3'd7;

  localparam logic [11:0] SYS_ECALL  = 12'd0;
  localparam logic [11:0] SYS_EBREAK = 12'd1;

  // Instruction codes
  localparam inst_code_t IC_NONE   = 6'd0;
  localparam inst_code_t IC_LUI    = 6'd1;
  localparam inst_code_t IC_AUIPC  = 6'd2;
  localparam inst_code_t IC_JAL    = 6'd3;
  localparam inst_code_t IC_JALR   = 6'd4;
  localparam inst_code_t IC_BEQ    = 6'd5;
  localparam inst_code_t IC_BNE    = 6'd6;
  localparam inst_code_t IC_BLT    = 6'd7;
  localparam inst_code_t IC_BGE    = 6'd8;
  localparam inst_code_t IC_BLTU   = 6'd9;
  localparam inst_code_t IC_BGEU   = 6'd10;
  localparam inst_code_t IC_LB     = 6'd11;
  localparam inst_code_t IC_LH     = 6'd12;
  localparam inst_code_t IC_LW     = 6'd13;
  localparam inst_code_t IC_LBU    = 6'd14;
  localparam inst_code_t IC_LHU    = 6'd15;
  localparam inst_code_t IC_SB     = 6'd16;
  localparam inst_code_t IC_SH     = 6'd17;
  localparam inst_code_t IC_SW     = 6'd18;
  localparam inst_code_t IC_ADDI   = 6'd19;
  localparam inst_code_t IC_SLTI   = 6'd20;
  localparam inst_code_t IC_SLTIU  = 6'd21;
  localparam inst_code_t IC_XORI   = 6'd22;
  localparam inst_code_t IC_ORI    = 6'd23;
  localparam inst_code_t IC_ANDI   = 6'd24;
  localparam inst_code_t IC_SLLI   = 6'd25;
  localparam inst_code_t IC_SRLI   = 6'd26;
  localparam inst_code_t IC_SRAI   = 6'd27;
  localparam inst_code_t IC_ADD    = 6'd28;
  localparam inst_code_t IC_SUB    = 6'd29;
  localparam inst_code_t IC_SLL    = 6'd30;
  localparam inst_code_t IC_SLT    = 6'd31;
  localparam inst_code_t IC_SLTU   = 6'd32;
  localparam inst_code_t IC_XOR    = 6'd33;
  localparam inst_code_t IC_SRL    = 6'd34;
  localparam inst_code_t IC_SRA    = 6'd35;
  localparam inst_code_t IC_OR     = 6'd36;
  localparam inst_code_t IC_AND    = 6'd37;
  localparam inst_code_t IC_FENCE  = 6'd38;
  localparam inst_code_t IC_ECALL  = 6'd39;
  localparam inst_code_t IC_EBREAK = 6'd40;

  // Classify one instruction word; unknown encodings give IC_NONE.
  function automatic inst_code_t decode_inst(input instr_word_t w);
    opcode_t     opc;
    funct3_t     f3;
    funct7_t     f7;
    logic [11:0] imm;
    inst_code_t  code;
    opc  = w[6:0];
    f3   = w[14:12];
    f7   = w[31:25];
    imm  = w[31:20];
    code = IC_NONE;
    unique case (opc)
      OPC_LUI:   code = IC_LUI;
      OPC_AUIPC: code = IC_AUIPC;
      OPC_JAL:   code = IC_JAL;
      OPC_JALR:  code = (f3 == F3_0) ? IC_JALR : IC_NONE;
      OPC_BRANCH: begin
        unique case (f3)
          F3_0:    code = IC_BEQ;
          F3_1:    code = IC_BNE;
          F3_4:    code = IC_BLT;
          F3_5:    code = IC_BGE;
          F3_6:    code = IC_BLTU;
          F3_7:    code = IC_BGEU;
          default: code = IC_NONE;
        endcase
      end
      OPC_LOAD: begin
        unique case (f3)
          F3_0:    code = IC_LB;
          F3_1:    code = IC_LH;
          F3_2:    code = IC_LW;
          F3_4:    code = IC_LBU;
          F3_5:    code = IC_LHU;
          default: code = IC_NONE;
        endcase
      end
      OPC_STORE: begin
        unique case (f3)
          F3_0:    code = IC_SB;
          F3_1:    code = IC_SH;
          F3_2:    code = IC_SW;
          default: code = IC_NONE;
        endcase
      end
      OPC_OPIMM: begin
        unique case (f3)
          F3_0: code = IC_ADDI;
          F3_1: code = (f7 == F7_BASE) ? IC_SLLI : IC_NONE;
          F3_2: code = IC_SLTI;
          F3_3: code = IC_SLTIU;
          F3_4: code = IC_XORI;
          F3_5: begin
            if (f7 == F7_BASE) begin
              code = IC_SRLI;
            end else if (f7 == F7_ALT) begin
              code = IC_SRAI;
            end else begin
              code = IC_NONE;
            end
          end
          F3_6:    code = IC_ORI;
          default: code = IC_ANDI;
        endcase
      end
      OPC_OP: begin
        if (f7 == F7_BASE) begin
          unique case (f3)
            F3_0:    code = IC_ADD;
            F3_1:    code = IC_SLL;
            F3_2:    code = IC_SLT;
            F3_3:    code = IC_SLTU;
            F3_4:    code = IC_XOR;
            F3_5:    code = IC_SRL;
            F3_6:    code = IC_OR;
            default: code = IC_AND;
          endcase
        end else if (f7 == F7_ALT && f3 == F3_0) begin
          code = IC_SUB;
        end else if (f7 == F7_ALT && f3 == F3_5) begin
          code = IC_SRA;
        end else begin
          code = IC_NONE;
        end
      end
      OPC_FENCE: code = (f3 == F3_0) ? IC_FENCE : IC_NONE;
      OPC_SYSTEM: begin
        if (f3 != F3_0) begin
          code = IC_NONE;
        end else if (imm == SYS_ECALL) begin
          code = IC_ECALL;
        end else if (imm == SYS_EBREAK) begin
          code = IC_EBREAK;
        end else begin
          code = IC_NONE;
        end
      end
      default: code = IC_NONE;
    endcase
    return code;
  endfunction

endpackage

FILE: hdl/rv32i_instruction_decoder_top.sv
// Top level of the RV32I instruction decoder: input register, decode logic, result register.
//
// RV32I instruction decoder. Each input transaction carries one 32-bit
// instruction word; each output transaction carries its instruction code
// (0 for an unrecognized encoding, 1..40 for LUI through EBREAK) and the raw
// unsigned bit groups rd, rs1, rs2, funct7, bits 31..20 and bits 31..12.
// Immediates are not reassembled. The block is a two-register pipeline: the
// word is captured in an input register, decoded by a single level of
// opcode/funct3/funct7 compare logic, and the result is held in an output
// register. It accepts one word per clock cycle while out_ready stays high.
// Each stage advances when the stage after it is empty or being drained, so
// in_ready can stay high while a finished result waits on out_ready;
// back-pressure holds both stages and then drops in_ready. There is no
// configuration and no state beyond the pipeline; reset only empties the
// two stages.
module rv32i_instruction_decoder_top (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  rvdec_pkg::instr_word_t  in_instr_word,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rvdec_pkg::inst_code_t   out_inst_code,
  output logic [4:0]              out_rd_field,
  output logic [4:0]              out_rs1_field,
  output logic [4:0]              out_rs2_field,
  output logic [6:0]              out_funct7_field,
  output logic [11:0]             out_imm_low,
  output logic [19:0]             out_imm_high
);
  import rvdec_pkg::*;

  // Input stage
  logic        in_vld_r;
  instr_word_t word_r;

  // Result stage
  logic        out_vld_r;
  inst_code_t  code_r;
  logic [4:0]  rd_r;
  logic [4:0]  rs1_r;
  logic [4:0]  rs2_r;
  logic [6:0]  f7_r;
  logic [11:0] imm_low_r;
  logic [19:0] imm_high_r;

  logic        out_stage_ready;
  logic        in_stage_ready;
  logic        advance;
  inst_code_t  code_nxt;

  // Result stage can take a new item when empty or when its item leaves now.
  assign out_stage_ready = !out_vld_r || out_ready;
  assign in_stage_ready  = !in_vld_r || out_stage_ready;
  assign advance         = in_vld_r && out_stage_ready;
  assign in_ready        = in_stage_ready;

  assign code_nxt = decode_inst(word_r);

  // Control: stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_stage_ready) begin
        in_vld_r <= in_valid;
      end
      if (out_stage_ready) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  // Payload: capture the word on acceptance, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && in_stage_ready) begin
      word_r <= in_instr_word;
    end
  end

  // Payload: load decoded fields when the input stage advances
  always_ff @(posedge clk) begin
    if (advance) begin
      code_r     <= code_nxt;
      rd_r       <= word_r[11:7];
      rs1_r      <= word_r[19:15];
      rs2_r      <= word_r[24:20];
      f7_r       <= word_r[31:25];
      imm_low_r  <= word_r[31:20];
      imm_high_r <= word_r[31:12];
    end
  end

  assign out_valid        = out_vld_r;
  assign out_inst_code    = code_r;
  assign out_rd_field     = rd_r;
  assign out_rs1_field    = rs1_r;
  assign out_rs2_field    = rs2_r;
  assign out_funct7_field = f7_r;
  assign out_imm_low      = imm_low_r;
  assign out_imm_high     = imm_high_r;

endmodule
